### sv/fpes_pkg.sv
`default_nettype none

package fpes_pkg;

    // Largest program unit in bytes
    localparam int unsigned MAX_UNIT_DEF = 256;

    // Input opcodes (tuser of the input word)
    localparam logic [1:0] OP_STEP    = 2'd0;
    localparam logic [1:0] OP_PROGRAM = 2'd1;
    localparam logic [1:0] OP_ERASE   = 2'd2;

    // Output word kinds (tuser of the output word)
    localparam logic [1:0] KIND_CMD    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_UNLOCK_A = 2'd0;
    localparam logic [1:0] REG_UNLOCK_B = 2'd1;
    localparam logic [1:0] REG_UNIT     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] UNLOCK_A_RST = 16'h2AAA;
    localparam logic [15:0] UNLOCK_B_RST = 16'h5555;
    localparam logic [8:0]  UNIT_RST     = 9'd1;

    // Flash command bytes
    localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
    localparam logic [7:0] CMD_PROG    = 8'hA0;
    localparam logic [7:0] CMD_ERASE   = 8'h80;
    localparam logic [7:0] CMD_SECTOR  = 8'h10;
    localparam logic [7:0] ERASE_DONE  = 8'hFF;
    localparam int unsigned TOGGLE_POS = 6;

    // Index of the final word of each burst
    localparam logic [2:0] STATUS_LAST  = 3'd0;
    localparam logic [2:0] PROGRAM_LAST = 3'd3;
    localparam logic [2:0] ERASE_LAST   = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_ERASE        = 3'd1,
        PH_ERASE_WAIT   = 3'd2,
        PH_PROGRAM      = 3'd3,
        PH_TOGGLE_FIRST = 3'd4,
        PH_TOGGLE_CHECK = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_STATUS  = 2'd0,
        SEQ_ERASE   = 2'd1,
        SEQ_PROGRAM = 2'd2
    } t_seq;

endpackage

`default_nettype wire

### sv/flash_program_erase_sequencer.sv
`default_nettype none

// Program/erase sequencer for one parallel NOR flash channel. Start items
// (program, erase) load the job and return one status word; step items
// advance the job by at most one phase. A step in the erase phase returns six
// command words, a step in the program phase three command words and one
// data block word, every other item one status word. Output words leave one
// per cycle from a burst register while the output is ready; the next item
// is taken in the cycle the last word of the previous one is handed over, or
// at once when no burst is pending. Configure only while the block is idle.
module flash_program_erase_sequencer
    import fpes_pkg::*;
#(
    parameter int unsigned MAX_UNIT = MAX_UNIT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // start_address[15:0], total_length[31:16], status_byte[39:32],
    // page_matches[40], zero fill[47:41]
    input  wire logic [47:0] i_s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  i_s_tuser,
    // output words
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // bus_address[15:0], bus_data[23:16], source_offset[39:24],
    // byte_count[48:40], phase[51:49], zero fill[55:52]
    output logic [55:0]      o_m_tdata,
    // kind[1:0]
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tlast,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [12:0] MAX_UNIT_W = 13'(MAX_UNIT);

    // Configuration registers
    logic [15:0] r_unlock_a;
    logic [15:0] r_unlock_b;
    logic [8:0]  r_unit;

    // Job state
    t_phase      r_phase, n_phase;
    logic        r_is_erase, n_is_erase;
    logic [15:0] r_cur_address, n_cur_address;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_offset, n_offset;
    logic        r_toggle, n_toggle;

    // Output burst
    logic        r_busy;
    t_seq        r_seq, n_seq;
    logic [2:0]  r_idx;
    logic [15:0] r_addr;
    logic [15:0] r_off;
    logic [8:0]  r_cnt;
    t_phase      r_out_phase;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_last;
    logic [2:0]  w_last_idx;
    logic [8:0]  w_unit;
    logic [1:0]  w_opcode;
    logic [15:0] w_start_address;
    logic [15:0] w_total_length;
    logic [7:0]  w_status_byte;
    logic        w_page_matches;
    logic        w_tbit;
    logic [15:0] w_rem_adv;
    logic [1:0]  w_kind;
    logic [15:0] w_bus_address;
    logic [7:0]  w_bus_data;
    logic [15:0] w_src_off;
    logic [8:0]  w_byte_count;
    logic        w_cfg_wr;

    // Unpack the input word
    assign w_opcode        = i_s_tuser;
    assign w_start_address = i_s_tdata[15:0];
    assign w_total_length  = i_s_tdata[31:16];
    assign w_status_byte   = i_s_tdata[39:32];
    assign w_page_matches  = i_s_tdata[40];
    assign w_tbit          = w_status_byte[TOGGLE_POS];

    // Configuration write and read
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_a <= UNLOCK_A_RST;
            r_unlock_b <= UNLOCK_B_RST;
            r_unit     <= UNIT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_UNLOCK_A: r_unlock_a <= pwdata[15:0];
                REG_UNLOCK_B: r_unlock_b <= pwdata[15:0];
                REG_UNIT:     r_unit     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_UNLOCK_A: prdata = {16'd0, r_unlock_a};
            REG_UNLOCK_B: prdata = {16'd0, r_unlock_b};
            REG_UNIT:     prdata = {23'd0, r_unit};
            default:      prdata = 32'd0;
        endcase
    end

    // Effective unit: zero acts as one, saturate at the largest unit
    always_comb begin
        if (r_unit == 9'd0) begin
            w_unit = 9'd1;
        end else if ({4'd0, r_unit} > MAX_UNIT_W) begin
            w_unit = MAX_UNIT_W[8:0];
        end else begin
            w_unit = r_unit;
        end
    end

    // Remaining length after one unit, floor at zero
    assign w_rem_adv = (r_remaining <= {7'd0, w_unit}) ? 16'd0
                                                       : r_remaining - {7'd0, w_unit};

    // Handshakes
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign o_s_tready = !r_busy || (w_out_acc && w_last);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // Next job state and burst kind for the accepted word
    always_comb begin
        n_phase       = r_phase;
        n_is_erase    = r_is_erase;
        n_cur_address = r_cur_address;
        n_remaining   = r_remaining;
        n_offset      = r_offset;
        n_toggle      = r_toggle;
        n_seq         = SEQ_STATUS;
        unique case (w_opcode)
            OP_PROGRAM: begin
                n_phase       = PH_PROGRAM;
                n_is_erase    = 1'b0;
                n_cur_address = w_start_address;
                n_remaining   = w_total_length;
                n_offset      = 16'd0;
            end
            OP_ERASE: begin
                n_phase       = PH_ERASE;
                n_is_erase    = 1'b1;
                n_cur_address = w_start_address;
                n_remaining   = {7'd0, w_unit};
                n_offset      = 16'd0;
            end
            OP_STEP: begin
                unique case (r_phase)
                    PH_ERASE: begin
                        n_seq   = SEQ_ERASE;
                        n_phase = PH_ERASE_WAIT;
                    end
                    PH_ERASE_WAIT: begin
                        if (w_status_byte == ERASE_DONE) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_PROGRAM: begin
                        n_seq   = SEQ_PROGRAM;
                        n_phase = PH_TOGGLE_FIRST;
                    end
                    PH_TOGGLE_FIRST: begin
                        n_toggle = w_tbit;
                        n_phase  = PH_TOGGLE_CHECK;
                    end
                    PH_TOGGLE_CHECK: begin
                        n_toggle = w_tbit;
                        if (w_tbit == r_toggle) begin
                            if (w_unit != 9'd1 && !r_is_erase && !w_page_matches) begin
                                // page mismatch: program the same unit again
                                n_phase = PH_PROGRAM;
                            end else begin
                                n_cur_address = r_cur_address + {7'd0, w_unit};
                                n_offset      = r_offset + {7'd0, w_unit};
                                n_remaining   = w_rem_adv;
                                n_phase = (w_rem_adv == 16'd0 || r_is_erase) ? PH_IDLE
                                                                              : PH_PROGRAM;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Job state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_is_erase    <= 1'b0;
            r_cur_address <= 16'd0;
            r_remaining   <= 16'd0;
            r_offset      <= 16'd0;
            r_toggle      <= 1'b0;
        end else if (w_in_acc) begin
            r_phase       <= n_phase;
            r_is_erase    <= n_is_erase;
            r_cur_address <= n_cur_address;
            r_remaining   <= n_remaining;
            r_offset      <= n_offset;
            r_toggle      <= n_toggle;
        end
    end

    // Burst control: load on accept, advance on each word handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seq  <= SEQ_STATUS;
            r_idx  <= 3'd0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
            r_seq  <= n_seq;
            r_idx  <= 3'd0;
        end else if (w_out_acc) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 3'd1;
        end
    end

    // Burst payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_addr      <= n_cur_address;
            r_off       <= r_offset;
            r_cnt       <= w_unit;
            r_out_phase <= n_phase;
        end
    end

    // Last word of the current burst
    always_comb begin
        unique case (r_seq)
            SEQ_ERASE:   w_last_idx = ERASE_LAST;
            SEQ_PROGRAM: w_last_idx = PROGRAM_LAST;
            default:     w_last_idx = STATUS_LAST;
        endcase
    end
    assign w_last = (r_idx == w_last_idx);

    // Select the word at the current burst position
    always_comb begin
        w_kind        = KIND_STATUS;
        w_bus_address = r_addr;
        w_bus_data    = 8'd0;
        w_src_off     = 16'd0;
        w_byte_count  = 9'd0;
        unique case (r_seq)
            SEQ_ERASE: begin
                w_kind = KIND_CMD;
                unique case (r_idx)
                    3'd0: begin
                        w_bus_address = r_unlock_b;
                        w_bus_data    = CMD_UNLOCK1;
                    end
                    3'd1: begin
                        w_bus_address = r_unlock_a;
                        w_bus_data    = CMD_UNLOCK2;
                    end
                    3'd2: begin
                        w_bus_address = r_unlock_b;
                        w_bus_data    = CMD_ERASE;
                    end
                    3'd3: begin
                        w_bus_address = r_unlock_b;
                        w_bus_data    = CMD_UNLOCK1;
                    end
                    3'd4: begin
                        w_bus_address = r_unlock_a;
                        w_bus_data    = CMD_UNLOCK2;
                    end
                    default: begin
                        w_bus_address = r_unlock_b;
                        w_bus_data    = CMD_SECTOR;
                    end
                endcase
            end
            SEQ_PROGRAM: begin
                unique case (r_idx)
                    3'd0: begin
                        w_kind        = KIND_CMD;
                        w_bus_address = r_unlock_b;
                        w_bus_data    = CMD_UNLOCK1;
                    end
                    3'd1: begin
                        w_kind        = KIND_CMD;
                        w_bus_address = r_unlock_a;
                        w_bus_data    = CMD_UNLOCK2;
                    end
                    3'd2: begin
                        w_kind        = KIND_CMD;
                        w_bus_address = r_unlock_b;
                        w_bus_data    = CMD_PROG;
                    end
                    default: begin
                        w_kind       = KIND_DATA;
                        w_src_off    = r_off;
                        w_byte_count = r_cnt;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Output word
    assign o_m_tvalid = r_busy;
    assign o_m_tuser  = w_kind;
    assign o_m_tlast  = w_last;
    assign o_m_tdata  = {4'd0, r_out_phase, w_byte_count, w_src_off, w_bus_data,
                         w_bus_address};

    // A new word enters over a pending burst only as its last word leaves
    a_accept_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_busy) |-> (i_m_tready && w_last))
        else $error("input taken while burst still pending");

    // The burst position never runs past the end of its sequence
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= w_last_idx))
        else $error("burst index beyond sequence end");

    // A handed-over last word with no new input leaves the block idle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last && !i_s_tvalid) |=> !r_busy)
        else $error("burst did not drain");

    // Data block words only close a program burst
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_kind == KIND_DATA) |-> (r_seq == SEQ_PROGRAM && w_last))
        else $error("data word outside program burst end");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fpes_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 40;
    // opcode that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one word of the output stream, decoded
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic [15:0] source_offset;
        logic [8:0]  byte_count;
        logic [2:0]  phase;
        logic        last;
    } t_bus_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = OP_STEP;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // sequencer copy: configuration and job state
    logic [15:0] cfg_unlock_a = UNLOCK_A_RST;
    logic [15:0] cfg_unlock_b = UNLOCK_B_RST;
    logic [8:0]  cfg_unit = UNIT_RST;
    t_phase      job_phase = PH_IDLE;
    logic        job_is_erase = 1'b0;
    logic [15:0] job_address = '0;
    logic [15:0] job_remaining = '0;
    logic [15:0] job_offset = '0;
    logic        job_toggle = 1'b0;

    t_bus_word   expected_bus_words[$];
    int          error_count = 0;
    int          items_sent = 0;
    int unsigned cycle_count = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          rx_hold = 0;

    flash_program_erase_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // zero acts as one, anything above the maximum saturates
    function automatic logic [8:0] effective_unit();
        if (cfg_unit == 9'd0) return 9'd1;
        if (cfg_unit > 9'(MAX_UNIT_DEF)) return 9'(MAX_UNIT_DEF);
        return cfg_unit;
    endfunction

    function automatic t_bus_word make_word(input logic [1:0] kind,
                                            input logic [15:0] addr,
                                            input logic [7:0] data,
                                            input logic [15:0] offset,
                                            input logic [8:0] count);
        t_bus_word w;
        w.kind = kind;
        w.bus_address = addr;
        w.bus_data = data;
        w.source_offset = offset;
        w.byte_count = count;
        w.phase = PH_IDLE;
        w.last = 1'b0;
        return w;
    endfunction

    // advance the sequencer copy by one input item and queue its bus words
    task automatic predict_bus_words(input logic [1:0] op, input logic [15:0] addr,
                                     input logic [15:0] len, input logic [7:0] sb,
                                     input logic pm);
        t_bus_word burst[$];
        t_bus_word w;
        logic [8:0] unit;
        unit = effective_unit();
        case (op)
            OP_PROGRAM: begin
                job_phase = PH_PROGRAM;
                job_is_erase = 1'b0;
                job_address = addr;
                job_remaining = len;
                job_offset = '0;
            end
            OP_ERASE: begin
                job_phase = PH_ERASE;
                job_is_erase = 1'b1;
                job_address = addr;
                job_remaining = {7'd0, unit};
                job_offset = '0;
            end
            OP_STEP: begin
                case (job_phase)
                    PH_ERASE: begin
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_b, CMD_UNLOCK1, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_a, CMD_UNLOCK2, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_b, CMD_ERASE, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_b, CMD_UNLOCK1, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_a, CMD_UNLOCK2, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_b, CMD_SECTOR, 0, 0));
                        job_phase = PH_ERASE_WAIT;
                    end
                    PH_ERASE_WAIT: begin
                        if (sb == ERASE_DONE) job_phase = PH_IDLE;
                    end
                    PH_PROGRAM: begin
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_b, CMD_UNLOCK1, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_a, CMD_UNLOCK2, 0, 0));
                        burst.push_back(make_word(KIND_CMD, cfg_unlock_b, CMD_PROG, 0, 0));
                        burst.push_back(make_word(KIND_DATA, job_address, 0, job_offset, unit));
                        job_phase = PH_TOGGLE_FIRST;
                    end
                    PH_TOGGLE_FIRST: begin
                        job_toggle = sb[TOGGLE_POS];
                        job_phase = PH_TOGGLE_CHECK;
                    end
                    PH_TOGGLE_CHECK: begin
                        if (sb[TOGGLE_POS] == job_toggle && unit != 9'd1 && !job_is_erase
                                && !pm) begin
                            // page mismatch: program the same unit again
                            job_phase = PH_PROGRAM;
                        end else begin
                            if (sb[TOGGLE_POS] == job_toggle) begin
                                job_address = job_address + {7'd0, unit};
                                job_offset = job_offset + {7'd0, unit};
                                if (job_remaining <= {7'd0, unit}) job_remaining = '0;
                                else job_remaining = job_remaining - {7'd0, unit};
                                job_phase = (job_remaining == 0 || job_is_erase) ?
                                            PH_IDLE : PH_PROGRAM;
                            end
                            job_toggle = sb[TOGGLE_POS];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (burst.size() == 0)
            burst.push_back(make_word(KIND_STATUS, job_address, 0, 0, 0));
        foreach (burst[k]) begin
            w = burst[k];
            w.phase = job_phase;
            w.last = (k == burst.size() - 1);
            expected_bus_words.push_back(w);
        end
    endtask

    // take accepted items into the predictor, then check each output word
    always @(posedge i_clk) begin : word_monitor
        t_bus_word want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                predict_bus_words(i_s_tuser, i_s_tdata[15:0], i_s_tdata[31:16],
                                  i_s_tdata[39:32], i_s_tdata[40]);
            if (o_m_tvalid && i_m_tready) begin
                if (expected_bus_words.size() == 0) begin
                    report_mismatch("word with nothing expected", o_m_tdata[31:0], 0);
                end else begin
                    want = expected_bus_words.pop_front();
                    if (o_m_tuser != want.kind)
                        report_mismatch("kind", o_m_tuser, want.kind);
                    if (o_m_tdata[15:0] != want.bus_address)
                        report_mismatch("bus_address", o_m_tdata[15:0], want.bus_address);
                    if (o_m_tdata[23:16] != want.bus_data)
                        report_mismatch("bus_data", o_m_tdata[23:16], want.bus_data);
                    if (o_m_tdata[39:24] != want.source_offset)
                        report_mismatch("source_offset", o_m_tdata[39:24],
                                        want.source_offset);
                    if (o_m_tdata[48:40] != want.byte_count)
                        report_mismatch("byte_count", o_m_tdata[48:40], want.byte_count);
                    if (o_m_tdata[51:49] != want.phase)
                        report_mismatch("phase", o_m_tdata[51:49], want.phase);
                    if (o_m_tdata[55:52] != 4'd0)
                        report_mismatch("tdata fill", o_m_tdata[55:52], 0);
                    if (o_m_tlast != want.last)
                        report_mismatch("last", o_m_tlast, want.last);
                end
            end
        end
    end

    // output side: random stalls, plus a hold-off counted down here
    initial begin : word_receiver
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_m_tready = 1'b0;
                rx_hold--;
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                i_m_tready = 1'b0;
                repeat (pick_gap(1'b0)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // offer one item, hold it until accepted, then idle for a random gap, which may be none
    task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                             input logic [15:0] len, input logic [7:0] sb,
                             input logic pm);
        i_s_tuser = op;
        i_s_tdata = {7'd0, pm, sb, len, addr};
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        items_sent++;
        repeat (pick_gap(tx_steady)) @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (expected_bus_words.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // write one register, then read it back
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        case (idx)
            REG_UNLOCK_A: cfg_unlock_a = value[15:0];
            REG_UNLOCK_B: cfg_unlock_b = value[15:0];
            REG_UNIT:     cfg_unit = value[8:0];
            default: ;
        endcase
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_UNLOCK_A: want = {16'd0, cfg_unlock_a};
            REG_UNLOCK_B: want = {16'd0, cfg_unlock_b};
            default:      want = {23'd0, cfg_unit};
        endcase
        if (readback != want) report_mismatch("register readback", readback, want);
    endtask

    // change the settings once the block has gone quiet
    task automatic load_settings(input logic [15:0] addr_a, input logic [15:0] addr_b,
                                 input logic [8:0] unit);
        wait_for_drain();
        write_register(REG_UNLOCK_A, {16'd0, addr_a});
        write_register(REG_UNLOCK_B, {16'd0, addr_b});
        write_register(REG_UNIT, {23'd0, unit});
    endtask

    // start a program or erase job with random content and poll it along
    task automatic run_random_job(input int max_steps);
        int steps;
        logic [15:0] len;
        logic [7:0] sb;
        logic pm;
        case ($urandom_range(0, 3))
            0:       len = 16'($urandom);
            1:       len = 16'd0;
            default: len = 16'($urandom_range(1, 3 * effective_unit()));
        endcase
        if ($urandom_range(0, 99) < 65)
            send_item(OP_PROGRAM, 16'($urandom), len, 8'($urandom), 1'($urandom));
        else
            send_item(OP_ERASE, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        steps = 0;
        while (job_phase != PH_IDLE && steps < max_steps) begin
            sb = 8'($urandom);
            pm = ($urandom_range(0, 3) != 0);
            // steer the status toward completion, often in erase wait and mostly in toggle check
            if (job_phase == PH_ERASE_WAIT && $urandom_range(0, 2) == 0)
                sb = ERASE_DONE;
            if (job_phase == PH_TOGGLE_CHECK && $urandom_range(0, 9) < 7)
                sb[TOGGLE_POS] = job_toggle;
            if ($urandom_range(0, 19) == 0)
                send_item(2'($urandom), 16'($urandom), 16'($urandom), sb, pm);
            else
                send_item(OP_STEP, 16'($urandom), 16'($urandom), sb, pm);
            steps++;
        end
    endtask

    task automatic test_directed_sequences();
        // idle tick and unused opcode with every field at its top
        send_item(OP_STEP, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // zero length at the top address: one byte, address wraps
        send_item(OP_PROGRAM, 16'hFFFF, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h40, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h40, 1'b0);
        // sector erase, not done, then done
        send_item(OP_ERASE, 16'hFFF0, 16'hFFFF, 8'hFF, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'hFF, 1'b0);
        // long program: toggling, then stable, then abandoned by an erase
        send_item(OP_PROGRAM, 16'h1234, 16'hFFFF, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h40, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h40, 1'b1);
        send_item(OP_ERASE, 16'h8000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'hFF, 1'b0);
        // page device: mismatch retry, then short remainder ends the job
        load_settings(UNLOCK_A_RST, UNLOCK_B_RST, 9'd4);
        send_item(OP_PROGRAM, 16'hFFFE, 16'd6, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'hBF, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b0);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h40, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'hC0, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b1);
        send_item(OP_STEP, 16'h0000, 16'h0000, 8'h00, 1'b1);
    endtask

    task automatic test_register_settings();
        int mark;
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: load_settings(16'h0000, 16'hFFFF, 9'd1);
                1: load_settings(16'hFFFF, 16'h0000, 9'd256);
                2: load_settings(16'($urandom), 16'($urandom), 9'd0);
                3: load_settings(16'($urandom), 16'($urandom), 9'd511);
                4: load_settings(16'($urandom), 16'($urandom), 9'd2);
                default: load_settings(16'($urandom), 16'($urandom),
                                       9'($urandom_range(3, 255)));
            endcase
            mark = items_sent;
            while (items_sent < mark + 10) run_random_job(20);
        end
    endtask

    task automatic test_output_backpressure();
        int mark;
        load_settings(16'($urandom), 16'($urandom), 9'd16);
        // hold the output off while items keep coming back to back
        tx_steady = 1'b1;
        rx_hold = 400;
        mark = items_sent;
        while (items_sent < mark + 24) run_random_job(12);
        tx_steady = 1'b0;
        // pause the sender until every word is out
        wait_for_drain();
        mark = items_sent;
        while (items_sent < mark + 10) run_random_job(12);
    endtask

    task automatic test_random_jobs();
        int mark;
        int segment;
        segment = 0;
        while (items_sent < 220 || segment < 2) begin
            if ($urandom_range(0, 99) < 60)
                load_settings(16'($urandom), 16'($urandom), 9'($urandom_range(1, 8)));
            else
                load_settings(16'($urandom), 16'($urandom), 9'($urandom_range(0, 511)));
            // one stretch runs without idling on either side
            tx_steady = (segment == 1);
            rx_steady = (segment == 1);
            mark = items_sent;
            while (items_sent < mark + 20) run_random_job(24);
            segment++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_sequences();
        test_register_settings();
        test_output_backpressure();
        test_random_jobs();
        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
